@@ src/tlrf_pkg.sv @@
// ----------------------------------------------------------------------------
// tlrf_pkg
// Shared defaults, widths, item kinds and byte codes for the text line record framer.
// ----------------------------------------------------------------------------
package tlrf_pkg;

   // default configuration of the top level
   localparam int LINE_MAX_DEFAULT     = 128;
   localparam int SECTOR_BYTES_DEFAULT = 256;

   // payload widths
   localparam int IN_BYTE_W    = 8;
   localparam int CHUNK_BYTES  = 8;
   localparam int OUT_BYTES_W  = 8 * CHUNK_BYTES;
   localparam int BYTE_COUNT_W = 4;

   // item kinds
   localparam logic FUNC_TEXT = 1'b0;
   localparam logic FUNC_END  = 1'b1;

   // byte codes
   localparam logic [7:0] NEWLINE_CHAR  = 8'h0A;
   localparam logic [7:0] END_MARK_BYTE = 8'hFF;
   localparam logic [7:0] PAD_BYTE      = 8'h00;

endpackage

@@ src/tlrf_req_if.sv @@
// ----------------------------------------------------------------------------
// tlrf_req_if
// Input channel of the framer: one text byte or an end-of-text item.
// ----------------------------------------------------------------------------
interface tlrf_req_if;
   import tlrf_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 func;
   logic [IN_BYTE_W-1:0] in_byte;

   modport source (output valid, output func, output in_byte, input ready);
   modport sink   (input valid, input func, input in_byte, output ready);

endinterface

@@ src/tlrf_rsp_if.sv @@
// ----------------------------------------------------------------------------
// tlrf_rsp_if
// Result channel of the framer: one chunk of up to eight framed bytes.
// ----------------------------------------------------------------------------
interface tlrf_rsp_if;
   import tlrf_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [OUT_BYTES_W-1:0]  out_bytes;
   logic [BYTE_COUNT_W-1:0] byte_count;
   logic                    line_truncated;
   logic                    last_chunk;

   modport source (output valid, output out_bytes, output byte_count,
                   output line_truncated, output last_chunk, input ready);
   modport sink   (input valid, input out_bytes, input byte_count,
                   input line_truncated, input last_chunk, output ready);

endinterface

@@ src/text_line_record_framer.sv @@
// ----------------------------------------------------------------------------
// text_line_record_framer
// Frames a text byte stream into length-prefixed records, an end mark and
// zero fill to the sector boundary, delivered in chunks of up to 8 bytes.
// ----------------------------------------------------------------------------
// A text byte other than newline is stored without leaving the idle state,
// so the block stays ready. A newline or the end item starts the byte
// sequencer, which pushes one byte per cycle into the chunk packer unless
// held: a record is a two-byte length, the n stored bytes and a pad byte
// when n is odd; the end item adds two end mark bytes and zero fill to the
// sector boundary, and the flush state hands the final chunk to the output
// register. The sequencer holds while a full chunk waits for the output
// register to free up. The line store has one write port and one registered
// read port, fetched one entry ahead of the byte it feeds. Items after the
// end item are taken and dropped until reset. No clearing pass after reset.
module text_line_record_framer #(
   parameter int LINE_MAX     = tlrf_pkg::LINE_MAX_DEFAULT,
   parameter int SECTOR_BYTES = tlrf_pkg::SECTOR_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   tlrf_req_if.sink    req_ch,
   tlrf_rsp_if.source  rsp_ch
);
   import tlrf_pkg::*;

   localparam int AW    = $clog2(LINE_MAX);
   localparam int IW    = $clog2(LINE_MAX + 1);
   localparam int OFF_W = $clog2(SECTOR_BYTES);
   localparam int CNT_W = $clog2(CHUNK_BYTES + 1);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_LEN_HI = 10'b00_0000_0010,
      S_LEN_LO = 10'b00_0000_0100,
      S_DATA   = 10'b00_0000_1000,
      S_PAD    = 10'b00_0001_0000,
      S_MARK1  = 10'b00_0010_0000,
      S_MARK2  = 10'b00_0100_0000,
      S_FILL   = 10'b00_1000_0000,
      S_FLUSH  = 10'b01_0000_0000,
      S_DONE   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [IN_BYTE_W-1:0] line_mem [LINE_MAX];
   logic [IN_BYTE_W-1:0] rd_data_ff;

   logic [IW-1:0]    fill_ff, fill_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [OFF_W-1:0] off_ff, off_in, off_next;
   logic             prev_nl_ff, prev_nl_in;
   logic             ovf_ff, ovf_in;
   logic             is_end_ff, is_end_in;
   logic             trunc_ff, trunc_in;

   logic [OUT_BYTES_W-1:0] chunk_ff, chunk_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;

   logic                    out_valid_ff, out_valid_in;
   logic [OUT_BYTES_W-1:0]  out_bytes_ff, out_bytes_in;
   logic [BYTE_COUNT_W-1:0] out_count_ff, out_count_in;
   logic                    out_trunc_ff, out_trunc_in;
   logic                    out_last_ff, out_last_in;

   logic            req_xfer, out_free, emit, stall, put, rec_end, store_wr;
   logic [7:0]      byte_val;
   logic [15:0]     len16;
   logic [IW-1:0]   idx_inc;

   assign req_ch.ready = (state_ff == S_IDLE) || (state_ff == S_DONE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign len16        = 16'(fill_ff);
   assign idx_inc      = idx_ff + IW'(1);
   assign off_next     = (off_ff == OFF_W'(SECTOR_BYTES - 1)) ? '0 : off_ff + OFF_W'(1);

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.out_bytes      = out_bytes_ff;
   assign rsp_ch.byte_count     = out_count_ff;
   assign rsp_ch.line_truncated = out_trunc_ff;
   assign rsp_ch.last_chunk     = out_last_ff;

   // byte source of the sequencer
   always_comb begin
      emit     = 1'b0;
      byte_val = PAD_BYTE;
      case (state_ff)
         S_LEN_HI: begin
            emit     = 1'b1;
            byte_val = len16[15:8];
         end
         S_LEN_LO: begin
            emit     = 1'b1;
            byte_val = len16[7:0];
         end
         S_DATA: begin
            emit     = 1'b1;
            byte_val = rd_data_ff;
         end
         S_PAD, S_FILL: begin
            emit     = 1'b1;
            byte_val = PAD_BYTE;
         end
         S_MARK1, S_MARK2: begin
            emit     = 1'b1;
            byte_val = END_MARK_BYTE;
         end
         default: begin
            emit     = 1'b0;
            byte_val = PAD_BYTE;
         end
      endcase
      stall = emit && (cnt_ff == CNT_W'(CHUNK_BYTES)) && !out_free;
      put   = emit && !stall;
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      off_in       = off_ff;
      prev_nl_in   = prev_nl_ff;
      ovf_in       = ovf_ff;
      is_end_in    = is_end_ff;
      trunc_in     = trunc_ff;
      chunk_in     = chunk_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_bytes_in = out_bytes_ff;
      out_count_in = out_count_ff;
      out_trunc_in = out_trunc_ff;
      out_last_in  = out_last_ff;
      rec_end      = 1'b0;
      store_wr     = 1'b0;

      // chunk packer
      if (put) begin
         off_in = off_next;
         if (cnt_ff == CNT_W'(CHUNK_BYTES)) begin
            out_valid_in = 1'b1;
            out_bytes_in = chunk_ff;
            out_count_in = BYTE_COUNT_W'(CHUNK_BYTES);
            out_trunc_in = trunc_ff;
            out_last_in  = 1'b0;
            chunk_in     = OUT_BYTES_W'(byte_val);
            cnt_in       = CNT_W'(1);
         end else begin
            chunk_in = chunk_ff | (OUT_BYTES_W'(byte_val) << {cnt_ff[CNT_W-2:0], 3'b000});
            cnt_in   = cnt_ff + CNT_W'(1);
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               idx_in = '0;
               if (req_ch.func == FUNC_END) begin
                  is_end_in = 1'b1;
                  trunc_in  = prev_nl_ff ? 1'b0 : ovf_ff;
                  state_in  = prev_nl_ff ? S_MARK1 : S_LEN_HI;
               end else if (req_ch.in_byte == NEWLINE_CHAR) begin
                  is_end_in  = 1'b0;
                  trunc_in   = ovf_ff;
                  prev_nl_in = 1'b1;
                  state_in   = S_LEN_HI;
               end else begin
                  prev_nl_in = 1'b0;
                  if (fill_ff < IW'(LINE_MAX)) begin
                     store_wr = 1'b1;
                     fill_in  = fill_ff + IW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
            end
         end
         S_LEN_HI: begin
            if (put) begin
               state_in = S_LEN_LO;
            end
         end
         S_LEN_LO: begin
            if (put) begin
               if (fill_ff == '0) begin
                  rec_end = 1'b1;
               end else begin
                  state_in = S_DATA;
               end
            end
         end
         S_DATA: begin
            if (put) begin
               idx_in = idx_inc;
               if (idx_inc == fill_ff) begin
                  if (fill_ff[0]) begin
                     state_in = S_PAD;
                  end else begin
                     rec_end = 1'b1;
                  end
               end
            end
         end
         S_PAD: begin
            if (put) begin
               rec_end = 1'b1;
            end
         end
         S_MARK1: begin
            if (put) begin
               state_in = S_MARK2;
            end
         end
         S_MARK2, S_FILL: begin
            if (put) begin
               state_in = (off_next == '0) ? S_FLUSH : S_FILL;
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_bytes_in = chunk_ff;
               out_count_in = BYTE_COUNT_W'(cnt_ff);
               out_trunc_in = trunc_ff;
               out_last_in  = 1'b1;
               chunk_in     = '0;
               cnt_in       = '0;
               state_in     = is_end_ff ? S_DONE : S_IDLE;
            end
         end
         S_DONE: begin
            state_in = S_DONE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // record finished: line store is free again
      if (rec_end) begin
         fill_in  = '0;
         ovf_in   = 1'b0;
         state_in = is_end_ff ? S_MARK1 : S_FLUSH;
      end
   end

   // line store, read one entry ahead of the data byte
   always_ff @(posedge clock) begin
      if (store_wr) begin
         line_mem[fill_ff[AW-1:0]] <= req_ch.in_byte;
      end
      if (idx_in < IW'(LINE_MAX)) begin
         rd_data_ff <= line_mem[idx_in[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         idx_ff       <= '0;
         off_ff       <= '0;
         prev_nl_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
         is_end_ff    <= 1'b0;
         trunc_ff     <= 1'b0;
         chunk_ff     <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         off_ff       <= off_in;
         prev_nl_ff   <= prev_nl_in;
         ovf_ff       <= ovf_in;
         is_end_ff    <= is_end_in;
         trunc_ff     <= trunc_in;
         chunk_ff     <= chunk_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_bytes_ff <= out_bytes_in;
      out_count_ff <= out_count_in;
      out_trunc_ff <= out_trunc_in;
      out_last_ff  <= out_last_in;
   end

   // the stored line never grows past the buffer
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= IW'(LINE_MAX))
      else $error("line fill beyond buffer size");

   // the chunk packer never holds more than one chunk
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CHUNK_BYTES))
      else $error("chunk packer overfilled");

   // a chunk transfer always carries at least one and at most eight bytes
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.byte_count != '0) &&
                       (rsp_ch.byte_count <= BYTE_COUNT_W'(CHUNK_BYTES)))
      else $error("chunk with bad byte count");

   // once the end item has been framed the block stays finished
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> (state_ff == S_DONE))
      else $error("left finished state without reset");

   // the final chunk of an end item lands on a sector boundary
   a_sector_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH) && is_end_ff |-> (off_ff == '0))
      else $error("end fill does not reach sector boundary");

endmodule

@@ sim/text_line_record_framer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_line_record_framer_tb
// Self-checking bench for the text record framer. A short table of text
// rows, some with the chunk typed in, is followed by random lines. The
// run then ends with the end-of-text item and a few items that must be
// dropped. Every chunk is checked against a line and chunk predictor,
// with random gaps on the request side and random stalls on the chunk side.
// ----------------------------------------------------------------------------
module text_line_record_framer_tb;
   import tlrf_pkg::*;

   localparam int LINE_LIMIT     = LINE_MAX_DEFAULT;
   localparam int SECTOR_LEN     = SECTOR_BYTES_DEFAULT;
   localparam int RANDOM_ITEMS   = 120;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PRINT_LIMIT    = 40;

   typedef struct packed {
      logic [OUT_BYTES_W-1:0]  data;
      logic [BYTE_COUNT_W-1:0] count;
      logic                    cut;
      logic                    last;
   } chunk_type;

   typedef struct packed {
      logic                    func;
      logic [7:0]              data;
      logic [7:0]              reps;
      logic                    typed;
      logic [OUT_BYTES_W-1:0]  want_data;
      logic [BYTE_COUNT_W-1:0] want_count;
   } stim_row_type;

   typedef enum {END_AFTER_NEWLINE, END_OPEN_LINE, END_ON_SECTOR} ending_type;

   // typed rows are single-chunk records with cut low and last high
   localparam stim_row_type DIRECTED [0:18] = '{
      '{FUNC_TEXT, NEWLINE_CHAR, 8'd1,   1'b1, 64'h0, 4'd2},
      '{FUNC_TEXT, 8'h00,        8'd1,   1'b0, 64'h0, 4'd0},
      '{FUNC_TEXT, NEWLINE_CHAR, 8'd1,   1'b1, 64'h0000_0000_0000_0100, 4'd4},
      '{FUNC_TEXT, 8'hFF,        8'd1,   1'b0, 64'h0, 4'd0},
      '{FUNC_TEXT, 8'h0B,        8'd1,   1'b0, 64'h0, 4'd0},
      '{FUNC_TEXT, 8'h09,        8'd1,   1'b0, 64'h0, 4'd0},
      '{FUNC_TEXT, NEWLINE_CHAR, 8'd1,   1'b1, 64'h0000_0009_0BFF_0300, 4'd6},
      '{FUNC_TEXT, 8'h80,        8'd1,   1'b0, 64'h0, 4'd0},
      '{FUNC_TEXT, 8'h7F,        8'd1,   1'b0, 64'h0, 4'd0},
      '{FUNC_TEXT, 8'h01,        8'd1,   1'b0, 64'h0, 4'd0},
      '{FUNC_TEXT, 8'hFE,        8'd1,   1'b0, 64'h0, 4'd0},
      '{FUNC_TEXT, 8'h55,        8'd1,   1'b0, 64'h0, 4'd0},
      '{FUNC_TEXT, 8'hAA,        8'd1,   1'b0, 64'h0, 4'd0},
      '{FUNC_TEXT, NEWLINE_CHAR, 8'd1,   1'b1, 64'hAA55_FE01_7F80_0600, 4'd8},
      '{FUNC_TEXT, 8'h41,        8'd7,   1'b0, 64'h0, 4'd0},
      '{FUNC_TEXT, NEWLINE_CHAR, 8'd1,   1'b0, 64'h0, 4'd0},
      // line past the store size, then an empty line to see the flag clear
      '{FUNC_TEXT, 8'hC3,        8'd130, 1'b0, 64'h0, 4'd0},
      '{FUNC_TEXT, NEWLINE_CHAR, 8'd1,   1'b0, 64'h0, 4'd0},
      '{FUNC_TEXT, NEWLINE_CHAR, 8'd1,   1'b1, 64'h0, 4'd2}
   };

   logic clock;
   logic reset;

   tlrf_req_if req_ch ();
   tlrf_rsp_if rsp_ch ();

   text_line_record_framer u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // predictor state
   logic [7:0] line_buf [LINE_LIMIT];
   int         line_len      = 0;
   int         sector_pos    = 0;
   logic       after_newline = 1'b0;
   logic       cut_seen      = 1'b0;
   logic       text_closed   = 1'b0;

   // chunk being packed for the current item
   logic [OUT_BYTES_W-1:0] stage_data = '0;
   int                     stage_len  = 0;
   logic                   stage_cut  = 1'b0;
   int                     item_chunks = 0;

   chunk_type expected_chunks [$];

   int errors       = 0;
   int chunks_seen  = 0;
   int items_sent   = 0;
   int idle_cycles  = 0;
   int req_idle_pct = 30;
   int rsp_idle_pct = 30;
   int rsp_hold     = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   task automatic report(input string msg);
      errors++;
      if (errors <= PRINT_LIMIT)
         $display("%0t mismatch: %s", $time, msg);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      if (r < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void retune_idling();
      if ($urandom_range(0, 7) == 0) begin
         req_idle_pct = 0;
         rsp_idle_pct = 0;
      end else begin
         req_idle_pct = $urandom_range(5, 60);
         rsp_idle_pct = $urandom_range(5, 60);
      end
   endfunction

   function automatic void seal_chunk();
      chunk_type c;
      if (stage_len == 0)
         return;
      c.data  = stage_data;
      c.count = stage_len[BYTE_COUNT_W-1:0];
      c.cut   = stage_cut;
      c.last  = 1'b0;
      expected_chunks.push_back(c);
      item_chunks++;
      stage_data = '0;
      stage_len  = 0;
   endfunction

   function automatic void pack_byte(input logic [7:0] b);
      stage_data[8*stage_len +: 8] = b;
      stage_len++;
      sector_pos = (sector_pos + 1) % SECTOR_LEN;
      if (stage_len == CHUNK_BYTES)
         seal_chunk();
   endfunction

   // big-endian length, stored bytes, pad to even length
   function automatic void frame_record();
      logic [15:0] n;
      n = line_len[15:0];
      stage_cut = cut_seen;
      pack_byte(n[15:8]);
      pack_byte(n[7:0]);
      for (int i = 0; i < line_len; i++)
         pack_byte(line_buf[i]);
      if (n[0])
         pack_byte(PAD_BYTE);
      line_len = 0;
      cut_seen = 1'b0;
   endfunction

   function automatic void frame_item(input logic f, input logic [7:0] b);
      int        fill;
      chunk_type c;
      item_chunks = 0;
      stage_data  = '0;
      stage_len   = 0;
      stage_cut   = 1'b0;
      if (text_closed)
         return;
      if (f == FUNC_TEXT) begin
         if (b == NEWLINE_CHAR) begin
            frame_record();
            after_newline = 1'b1;
         end else begin
            if (line_len < LINE_LIMIT) begin
               line_buf[line_len] = b;
               line_len++;
            end else begin
               cut_seen = 1'b1;
            end
            after_newline = 1'b0;
         end
      end else begin
         if (!after_newline)
            frame_record();
         pack_byte(END_MARK_BYTE);
         pack_byte(END_MARK_BYTE);
         if (sector_pos != 0) begin
            fill = SECTOR_LEN - sector_pos;
            repeat (fill) pack_byte(PAD_BYTE);
         end
         text_closed = 1'b1;
      end
      seal_chunk();
      if (item_chunks > 0) begin
         c = expected_chunks.pop_back();
         c.last = 1'b1;
         expected_chunks.push_back(c);
      end
   endfunction

   task automatic send_item(input logic f, input logic [7:0] b);
      int gap;
      gap = ($urandom_range(0, 99) < req_idle_pct) ? pick_gap() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.func    <= f;
      req_ch.in_byte <= b;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      items_sent++;
      frame_item(f, b);
   endtask

   // text bytes with newline steered away, optionally closed by a newline
   task automatic send_line(input int len, input bit terminate);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom_range(0, 255));
         if (b == NEWLINE_CHAR)
            b = b ^ 8'h80;
         send_item(FUNC_TEXT, b);
      end
      if (terminate)
         send_item(FUNC_TEXT, NEWLINE_CHAR);
   endtask

   task automatic check_chunk();
      chunk_type want;
      if (expected_chunks.size() == 0) begin
         report($sformatf("chunk %0d with nothing pending: %h count %0d",
                          chunks_seen, rsp_ch.out_bytes, rsp_ch.byte_count));
         chunks_seen++;
         return;
      end
      want = expected_chunks.pop_front();
      if (rsp_ch.out_bytes !== want.data)
         report($sformatf("chunk %0d out_bytes %h, want %h",
                          chunks_seen, rsp_ch.out_bytes, want.data));
      if (rsp_ch.byte_count !== want.count)
         report($sformatf("chunk %0d byte_count %0d, want %0d",
                          chunks_seen, rsp_ch.byte_count, want.count));
      if (rsp_ch.line_truncated !== want.cut)
         report($sformatf("chunk %0d line_truncated %b, want %b",
                          chunks_seen, rsp_ch.line_truncated, want.cut));
      if (rsp_ch.last_chunk !== want.last)
         report($sformatf("chunk %0d last_chunk %b, want %b",
                          chunks_seen, rsp_ch.last_chunk, want.last));
      chunks_seen++;
   endtask

   // chunk side stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold = 0;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < rsp_idle_pct) begin
         rsp_hold = pick_gap() - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // chunk check and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            check_chunk();
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[text_line_record_framer] ERROR");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type row;
      chunk_type    typed_chunk;
      ending_type   ending;
      int           random_sent;
      int           r;
      int           len;
      int           need;

      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.func    <= FUNC_TEXT;
      req_ch.in_byte <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         row = DIRECTED[i];
         repeat (row.reps) send_item(row.func, row.data);
         if (row.typed) begin
            if (item_chunks != 1) begin
               report($sformatf("row %0d predicted %0d chunks", i, item_chunks));
            end else begin
               typed_chunk = expected_chunks.pop_back();
               typed_chunk.data  = row.want_data;
               typed_chunk.count = row.want_count;
               typed_chunk.cut   = 1'b0;
               typed_chunk.last  = 1'b1;
               expected_chunks.push_back(typed_chunk);
            end
         end
      end

      // mostly well-formed lines, some raw noise that may hold newlines
      random_sent = items_sent;
      while (items_sent - random_sent < RANDOM_ITEMS) begin
         retune_idling();
         r = $urandom_range(0, 99);
         if (r < 6) begin
            repeat ($urandom_range(1, 6))
               send_item(FUNC_TEXT, 8'($urandom_range(0, 255)));
         end else begin
            if (r < 60)
               len = $urandom_range(0, 12);
            else if (r < 88)
               len = $urandom_range(13, 60);
            else if (r < 96)
               len = $urandom_range(61, LINE_LIMIT);
            else
               len = $urandom_range(LINE_LIMIT + 1, LINE_LIMIT + 12);
            send_line(len, 1'b1);
         end
      end

      retune_idling();
      ending = ending_type'($urandom_range(0, 2));
      case (ending)
         END_AFTER_NEWLINE: begin
            if (!after_newline)
               send_item(FUNC_TEXT, NEWLINE_CHAR);
         end
         END_OPEN_LINE: begin
            send_line($urandom_range(1, LINE_LIMIT + 12), 1'b0);
         end
         default: begin
            // land the end mark exactly on a sector boundary: no fill
            if (!after_newline)
               send_item(FUNC_TEXT, NEWLINE_CHAR);
            need = (2 * SECTOR_LEN - 4 - sector_pos) % SECTOR_LEN;
            while (need == 0 || need > LINE_LIMIT) begin
               send_line(60, 1'b1);
               need = (2 * SECTOR_LEN - 4 - sector_pos) % SECTOR_LEN;
            end
            send_line(need, 1'b0);
         end
      endcase
      send_item(FUNC_END, 8'($urandom_range(0, 255)));

      // dropped until reset
      repeat (8)
         send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      req_ch.valid <= 1'b0;

      while (expected_chunks.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (errors == 0)
         $display("[text_line_record_framer] OK");
      else
         $display("[text_line_record_framer] ERROR");
      $finish;
   end

endmodule
